/* hdl/wpo_pkg.sv */
package wpo_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int PHASE_W     = 32;
   localparam int INDEX_W     = 11;
   localparam int OPCODE_W    = 2;
   localparam int OSR_W       = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   // wide enough to hold the largest table length, 65536
   localparam int SPAN_W      = 17;
   localparam int TICK_MAX_SAMPLES = 8;
   localparam int CNT_W       = 3;

   localparam logic [OPCODE_W-1:0] OP_LOAD        = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TICK        = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PHASE_RESET = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_INCREMENT     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERSAMPLE_EXPONENT = 2'd1;

   localparam logic [OSR_W-1:0] OSR_RESET = 2'd2;

   typedef struct packed {
      logic                       valid;
      logic                       is_write;
      logic [PHASE_W-1:0]         phase;
      logic [INDEX_W-1:0]         wr_index;
      logic signed [SAMPLE_W-1:0] wr_value;
      logic                       wrapped;
      logic                       last;
   } issue_type;

   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] t0;
      logic signed [SAMPLE_W-1:0] t1;
      logic [PHASE_W-1:0]         frac;
      logic                       wrapped;
      logic                       last;
   } lookup_type;

endpackage

/* hdl/wpo_if.sv */
interface wpo_req_if;
   import wpo_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [OPCODE_W-1:0]        opcode;
   logic [INDEX_W-1:0]         table_index;
   logic signed [SAMPLE_W-1:0] table_value;
   logic [PHASE_W-1:0]         phase_offset;

   modport source (output valid, opcode, table_index, table_value, phase_offset,
                   input ready);
   modport sink   (input valid, opcode, table_index, table_value, phase_offset,
                   output ready);
endinterface

interface wpo_rsp_if;
   import wpo_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic                       phase_wrapped;
   logic                       last_of_tick;

   modport source (output valid, sample_out, phase_wrapped, last_of_tick,
                   input ready);
   modport sink   (input valid, sample_out, phase_wrapped, last_of_tick,
                   output ready);
endinterface

interface wpo_csr_if;
   import wpo_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/wpo_sequencer.sv */
module wpo_sequencer #(
   parameter int MAX_OVERSAMPLE = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   wpo_req_if.sink                        req_chan,
   input  logic [wpo_pkg::PHASE_W-1:0]    phase_increment,
   input  logic [wpo_pkg::OSR_W-1:0]      oversample_exponent,
   input  logic                           advance,
   output wpo_pkg::issue_type             issue
);
   import wpo_pkg::*;

   localparam logic [CNT_W:0] MAX_CNT = (CNT_W+1)'(MAX_OVERSAMPLE);

   logic                       cmd_valid_ff;
   logic [OPCODE_W-1:0]        cmd_opcode_ff;
   logic [INDEX_W-1:0]         cmd_index_ff;
   logic signed [SAMPLE_W-1:0] cmd_value_ff;
   logic [PHASE_W-1:0]         cmd_offset_ff;
   logic [PHASE_W-1:0]         acc_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       wrap_ff;
   issue_type                  issue_ff;
   issue_type                  issue_in;

   logic [CNT_W:0]     samples;
   logic [CNT_W:0]     samples_m1;
   logic [CNT_W-1:0]   last_cnt;
   logic [PHASE_W-1:0] step;
   logic [PHASE_W-1:0] acc_next;
   logic               carry;
   logic               is_tick;
   logic               is_last;
   logic               item_done;
   logic               fire;
   logic               take;

   always_comb begin
      samples = (CNT_W+1)'(1) << oversample_exponent;
      if (samples > MAX_CNT) begin
         samples = MAX_CNT;
      end
      samples_m1 = samples - (CNT_W+1)'(1);
      last_cnt   = samples_m1[CNT_W-1:0];
   end

   assign step              = phase_increment >> oversample_exponent;
   assign {carry, acc_next} = {1'b0, acc_ff} + {1'b0, step};
   assign is_tick           = cmd_opcode_ff == OP_TICK;
   assign is_last           = cnt_ff == last_cnt;
   assign item_done         = !is_tick || is_last;
   assign fire              = cmd_valid_ff && advance;
   assign req_chan.ready    = !cmd_valid_ff || (advance && item_done);
   assign take              = req_chan.valid && req_chan.ready;

   always_comb begin
      issue_in.valid    = fire && (is_tick || cmd_opcode_ff == OP_LOAD);
      issue_in.is_write = !is_tick;
      issue_in.phase    = acc_ff + cmd_offset_ff;
      issue_in.wr_index = cmd_index_ff;
      issue_in.wr_value = cmd_value_ff;
      issue_in.wrapped  = wrap_ff || carry;
      issue_in.last     = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff   <= 1'b0;
         acc_ff         <= '0;
         cnt_ff         <= '0;
         wrap_ff        <= 1'b0;
         issue_ff.valid <= 1'b0;
      end else begin
         if (take) begin
            cmd_valid_ff <= 1'b1;
         end else if (fire && item_done) begin
            cmd_valid_ff <= 1'b0;
         end
         if (fire && is_tick) begin
            acc_ff  <= acc_next;
            cnt_ff  <= item_done ? '0 : cnt_ff + CNT_W'(1);
            wrap_ff <= item_done ? 1'b0 : (wrap_ff || carry);
         end else if (fire && cmd_opcode_ff == OP_PHASE_RESET) begin
            acc_ff <= '0;
         end
         if (advance) begin
            issue_ff <= issue_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_opcode_ff <= req_chan.opcode;
         cmd_index_ff  <= req_chan.table_index;
         cmd_value_ff  <= req_chan.table_value;
         cmd_offset_ff <= req_chan.phase_offset;
      end
   end

   assign issue = issue_ff;

endmodule

/* hdl/wpo_table_lookup.sv */
module wpo_table_lookup #(
   parameter int TABLE_LEN = 2048
) (
   input  logic                clock,
   input  logic                reset,
   input  wpo_pkg::issue_type  issue,
   input  logic                advance,
   output wpo_pkg::lookup_type look
);
   import wpo_pkg::*;

   localparam int              ADDR_W = $clog2(TABLE_LEN);
   localparam int              PROD_W = PHASE_W + SPAN_W;
   localparam logic [SPAN_W-1:0] LEN  = SPAN_W'(TABLE_LEN);

   logic signed [SAMPLE_W-1:0] mem [TABLE_LEN];

   logic [PROD_W-1:0] pos;
   logic [ADDR_W-1:0] i0;
   logic [ADDR_W-1:0] i1;
   logic [SPAN_W-1:0] i0_plus;
   logic [SPAN_W-1:0] wr_wide;
   logic              wr_ok;
   logic [ADDR_W-1:0] wr_addr;

   logic                       valid_ff;
   logic signed [SAMPLE_W-1:0] t0_ff;
   logic signed [SAMPLE_W-1:0] t1_ff;
   logic [PHASE_W-1:0]         frac_ff;
   logic                       wrapped_ff;
   logic                       last_ff;

   assign pos     = PROD_W'(issue.phase) * PROD_W'(LEN);
   assign i0      = pos[PHASE_W +: ADDR_W];
   assign i0_plus = SPAN_W'(i0) + SPAN_W'(1);
   assign i1      = (i0_plus == LEN) ? '0 : i0_plus[ADDR_W-1:0];
   assign wr_wide = SPAN_W'(issue.wr_index);
   assign wr_ok   = wr_wide < LEN;
   assign wr_addr = wr_wide[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (advance && issue.valid && issue.is_write && wr_ok) begin
         mem[wr_addr] <= issue.wr_value;
      end
      if (advance) begin
         t0_ff      <= mem[i0];
         t1_ff      <= mem[i1];
         frac_ff    <= pos[PHASE_W-1:0];
         wrapped_ff <= issue.wrapped;
         last_ff    <= issue.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= issue.valid && !issue.is_write;
      end
   end

   always_comb begin
      look.valid   = valid_ff;
      look.t0      = t0_ff;
      look.t1      = t1_ff;
      look.frac    = frac_ff;
      look.wrapped = wrapped_ff;
      look.last    = last_ff;
   end

endmodule

/* hdl/wpo_interp.sv */
module wpo_interp (
   input  logic                clock,
   input  logic                reset,
   input  wpo_pkg::lookup_type look,
   output logic                advance,
   wpo_rsp_if.source           rsp_chan
);
   import wpo_pkg::*;

   localparam int MUL_W = SAMPLE_W + 1 + PHASE_W + 1;
   localparam int DEL_W = MUL_W - PHASE_W;

   logic signed [SAMPLE_W:0]   diff;
   logic signed [PHASE_W:0]    frac_s;
   logic signed [MUL_W-1:0]    prod;
   logic signed [MUL_W-1:0]    rounded;
   logic signed [DEL_W-1:0]    delta;
   logic signed [DEL_W-1:0]    sum;

   logic                       mul_valid_ff;
   logic signed [MUL_W-1:0]    prod_ff;
   logic signed [SAMPLE_W-1:0] t0_ff;
   logic                       wrapped_ff;
   logic                       last_ff;

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       rsp_wrapped_ff;
   logic                       rsp_last_ff;

   assign advance = !rsp_valid_ff || rsp_chan.ready;

   assign diff    = (SAMPLE_W+1)'(look.t1) - (SAMPLE_W+1)'(look.t0);
   assign frac_s  = {1'b0, look.frac};
   assign prod    = MUL_W'(diff) * MUL_W'(frac_s);

   // round half up, then floor by the arithmetic shift
   assign rounded = prod_ff + (MUL_W'(1) <<< (PHASE_W - 1));
   assign delta   = rounded[MUL_W-1:PHASE_W];
   assign sum     = DEL_W'(t0_ff) + delta;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= look.valid;
         rsp_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff        <= prod;
         t0_ff          <= look.t0;
         wrapped_ff     <= look.wrapped;
         last_ff        <= look.last;
         sample_ff      <= sum[SAMPLE_W-1:0];
         rsp_wrapped_ff <= wrapped_ff;
         rsp_last_ff    <= last_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.sample_out    = sample_ff;
   assign rsp_chan.phase_wrapped = rsp_wrapped_ff;
   assign rsp_chan.last_of_tick  = rsp_last_ff;

endmodule

/* hdl/wavetable_phase_oscillator.sv */
// Wavetable oscillator with a Q0.32 phase accumulator and linear interpolation
// over a table of TABLE_LEN signed Q1.15 words. A load request writes one table
// word and a phase-reset request zeroes the phase; each is one sequencer step.
// A tick request holds the sequencer for 2^oversample_exponent lookups (capped
// at MAX_OVERSAMPLE, so 1 to 8), issuing one lookup per cycle through the two
// table read ports and yielding one response per cycle while not stalled; the
// next request is accepted during the last lookup of a tick, so requests follow
// with no gap. A lookup passes the issue, table read, multiply and output
// registers, and the whole pipe stalls only while a response waits at the output.
// The table has no reset: every entry a tick may read must be loaded first.
module wavetable_phase_oscillator #(
   parameter int TABLE_LEN      = 2048,
   parameter int MAX_OVERSAMPLE = 8
) (
   input  logic      clock,
   input  logic      reset,
   wpo_req_if.sink   req_chan,
   wpo_rsp_if.source rsp_chan,
   wpo_csr_if.sink   csr_chan
);
   import wpo_pkg::*;

   logic [PHASE_W-1:0] phase_increment_ff;
   logic [OSR_W-1:0]   oversample_exponent_ff;
   logic               advance;
   issue_type          issue;
   lookup_type         look;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_increment_ff     <= '0;
         oversample_exponent_ff <= OSR_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_PHASE_INCREMENT: begin
               phase_increment_ff <= csr_chan.data;
            end
            CSR_OVERSAMPLE_EXPONENT: begin
               oversample_exponent_ff <= csr_chan.data[OSR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   wpo_sequencer #(
      .MAX_OVERSAMPLE (MAX_OVERSAMPLE)
   ) u_sequencer (
      .clock               (clock),
      .reset               (reset),
      .req_chan            (req_chan),
      .phase_increment     (phase_increment_ff),
      .oversample_exponent (oversample_exponent_ff),
      .advance             (advance),
      .issue               (issue)
   );

   wpo_table_lookup #(
      .TABLE_LEN (TABLE_LEN)
   ) u_table_lookup (
      .clock   (clock),
      .reset   (reset),
      .issue   (issue),
      .advance (advance),
      .look    (look)
   );

   wpo_interp u_interp (
      .clock    (clock),
      .reset    (reset),
      .look     (look),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

endmodule

/* hdl/wpo_checker.sv */
module wpo_assertions (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [wpo_pkg::OPCODE_W-1:0]   req_opcode,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [wpo_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   input logic                           rsp_phase_wrapped,
   input logic                           rsp_last_of_tick
);
   import wpo_pkg::*;

   localparam int PEND_W = 4;

   logic              req_take;
   logic              rsp_take;
   logic [PEND_W-1:0] pending_ff;
   logic [CNT_W-1:0]  run_ff;
   logic              wrap_seen_ff;
   logic              tick_in;
   logic              tick_out;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;
   assign tick_in  = req_take && req_opcode == OP_TICK;
   assign tick_out = rsp_take && rsp_last_of_tick;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         run_ff       <= '0;
         wrap_seen_ff <= 1'b0;
      end else begin
         pending_ff <= pending_ff + PEND_W'(tick_in) - PEND_W'(tick_out);
         if (tick_out) begin
            run_ff       <= '0;
            wrap_seen_ff <= 1'b0;
         end else if (rsp_take) begin
            run_ff       <= run_ff + CNT_W'(1);
            wrap_seen_ff <= wrap_seen_ff || rsp_phase_wrapped;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
         && $stable(rsp_phase_wrapped) && $stable(rsp_last_of_tick))
      else $error("response changed while stalled");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response without an open tick request");

   a_wrap_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_take && wrap_seen_ff |-> rsp_phase_wrapped)
      else $error("phase wrap flag dropped within a tick");

   a_tick_length: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_last_of_tick |-> run_ff != CNT_W'(TICK_MAX_SAMPLES - 1))
      else $error("tick ran past the sample limit");

endmodule

bind wavetable_phase_oscillator wpo_assertions u_wpo_assertions (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_opcode        (req_chan.opcode),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_sample_out    (rsp_chan.sample_out),
   .rsp_phase_wrapped (rsp_chan.phase_wrapped),
   .rsp_last_of_tick  (rsp_chan.last_of_tick)
);
